[rtl/ipv4_cidr_pkg.sv]
// Package for the IPv4 CIDR text parser: word types, codes and field helper.
`default_nettype none

package ipv4_cidr_pkg;

    localparam int MAX_TOKEN_CHARS_DEF = 255;

    // parse phase codes
    localparam logic [1:0] PH_ADDR = 2'd0;
    localparam logic [1:0] PH_MASK = 2'd1;
    localparam logic [1:0] PH_DONE = 2'd2;

    // status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_OCTET   = 3'd1;
    localparam logic [2:0] ST_MISSING = 3'd2;
    localparam logic [2:0] ST_PREFIX  = 3'd3;
    localparam logic [2:0] ST_DOT     = 3'd4;

    localparam logic [9:0] ACC_CAP = 10'd1023;

    typedef struct packed {
        logic [7:0] char_code;
        logic       is_last;
    } in_word_t;

    typedef struct packed {
        logic [31:0] address;
        logic [31:0] netmask;
        logic [7:0]  consumed_length;
        logic [2:0]  status;
    } out_word_t;

    typedef struct packed {
        logic [2:0]  err;
        logic [31:0] shift;
    } field_t;

    // Close one octet field: flag empty or oversized, shift the octet in.
    function automatic field_t close_field(
        input logic        seen,
        input logic [9:0]  acc,
        input logic [2:0]  err,
        input logic [31:0] shift
    );
        field_t r;
        r.err = err;
        if (err == ST_OK)
        begin
            if (!seen)
                r.err = ST_MISSING;
            else if (acc > 10'd255)
                r.err = ST_OCTET;
        end
        r.shift = {shift[23:0], acc[7:0]};
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/ipv4_cidr_text_parser.sv]
// Top level of the IPv4 dotted-quad / CIDR token parser.
// The result register loads a word when the last character of its token is processed.
// Throughput: one character per cycle; the input register feeds one pass of
// character logic that updates the parse state and loads the result register.
// A waiting result only stalls the input when another last character meets it.
// Reset (rst_n low, asynchronous) empties both stages and returns to the address phase.
`default_nettype none

module ipv4_cidr_text_parser #(
    parameter int MAX_TOKEN_CHARS = ipv4_cidr_pkg::MAX_TOKEN_CHARS_DEF
) (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      in_valid,
    output logic                     in_stall,
    input  ipv4_cidr_pkg::in_word_t  in_word,
    output logic                     out_valid,
    input  wire                      out_stall,
    output ipv4_cidr_pkg::out_word_t out_word
);

    // character count saturates at the smaller of the limit and 255
    localparam int PosCapInt = (MAX_TOKEN_CHARS < 255) ? MAX_TOKEN_CHARS : 255;
    localparam logic [7:0] POS_CAP = 8'(PosCapInt);

    // input register
    logic                    s1_valid_reg;
    ipv4_cidr_pkg::in_word_t s1_word_reg;

    // parse state
    logic [1:0]  phase_reg,   phase_next;
    logic [2:0]  fcount_reg,  fcount_next;
    logic [9:0]  acc_reg,     acc_next;
    logic        seen_reg,    seen_next;
    logic [31:0] addr_reg,    addr_next;
    logic [31:0] mask_reg,    mask_next;
    logic [2:0]  err_reg,     err_next;
    logic [7:0]  pos_reg,     pos_next;

    // result register
    logic                     out_valid_reg;
    ipv4_cidr_pkg::out_word_t out_word_reg, out_word_next;

    logic        out_blocked;
    logic        proc;
    logic        is_digit;
    logic        is_dot;
    logic        is_slash;
    logic        is_term;
    logic        do_finish;
    logic [13:0] acc_prod;
    logic [5:0]  pfx_shamt;
    ipv4_cidr_pkg::field_t fld;

    // A non-last character never needs the result register, so it moves on
    // even while an earlier result is stalled.
    assign out_blocked = out_valid_reg && out_stall;
    assign proc        = s1_valid_reg && (!s1_word_reg.is_last || !out_blocked);
    assign in_stall    = s1_valid_reg && !proc;

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    assign is_digit = (s1_word_reg.char_code inside {[8'h30:8'h39]});
    assign is_dot   = (s1_word_reg.char_code == 8'h2e);
    assign is_slash = (s1_word_reg.char_code == 8'h2f);
    // slash inside the mask part ends the text
    assign is_term  = !is_digit && !is_dot &&
                      !(is_slash && (phase_reg == ipv4_cidr_pkg::PH_ADDR));
    // finish runs at most once per token: at the terminator or at the last char
    assign do_finish = (phase_reg != ipv4_cidr_pkg::PH_DONE) &&
                       (is_term || s1_word_reg.is_last);

    assign acc_prod = ({4'd0, acc_reg} * 14'd10) +
                      {10'd0, s1_word_reg.char_code[3:0]};

    always_comb
    begin
        phase_next  = phase_reg;
        fcount_next = fcount_reg;
        acc_next    = acc_reg;
        seen_next   = seen_reg;
        addr_next   = addr_reg;
        mask_next   = mask_reg;
        err_next    = err_reg;
        pos_next    = pos_reg;
        fld         = '0;
        pfx_shamt   = '0;

        // character step
        if (phase_reg != ipv4_cidr_pkg::PH_DONE && !is_term)
        begin
            if (pos_reg < POS_CAP)
                pos_next = pos_reg + 8'd1;
            if (is_digit)
            begin
                acc_next  = (acc_prod > 14'(ipv4_cidr_pkg::ACC_CAP)) ?
                            ipv4_cidr_pkg::ACC_CAP : acc_prod[9:0];
                seen_next = 1'b1;
            end
            else if (is_dot)
            begin
                if (fcount_reg >= 3'd3)
                begin
                    if (err_reg == ipv4_cidr_pkg::ST_OK)
                        err_next = ipv4_cidr_pkg::ST_DOT;
                end
                else
                begin
                    fld = ipv4_cidr_pkg::close_field(seen_reg, acc_reg, err_reg,
                        (phase_reg == ipv4_cidr_pkg::PH_ADDR) ? addr_reg : mask_reg);
                    err_next = fld.err;
                    if (phase_reg == ipv4_cidr_pkg::PH_ADDR)
                        addr_next = fld.shift;
                    else
                        mask_next = fld.shift;
                    fcount_next = fcount_reg + 3'd1;
                    acc_next    = '0;
                    seen_next   = 1'b0;
                end
            end
            else
            begin
                // slash in the address part
                if (fcount_reg != 3'd3)
                begin
                    if (err_reg == ipv4_cidr_pkg::ST_OK)
                        err_next = ipv4_cidr_pkg::ST_MISSING;
                end
                else
                begin
                    fld = ipv4_cidr_pkg::close_field(seen_reg, acc_reg, err_reg, addr_reg);
                    err_next  = fld.err;
                    addr_next = fld.shift;
                end
                phase_next  = ipv4_cidr_pkg::PH_MASK;
                fcount_next = '0;
                acc_next    = '0;
                seen_next   = 1'b0;
            end
        end

        // end of the token text
        if (do_finish)
        begin
            if (phase_next == ipv4_cidr_pkg::PH_ADDR)
            begin
                if (fcount_next != 3'd3)
                begin
                    if (err_next == ipv4_cidr_pkg::ST_OK)
                        err_next = ipv4_cidr_pkg::ST_MISSING;
                end
                else
                begin
                    fld = ipv4_cidr_pkg::close_field(seen_next, acc_next, err_next,
                                                     addr_next);
                    err_next  = fld.err;
                    addr_next = fld.shift;
                end
                mask_next = 32'hffff_ffff;
            end
            else
            begin
                if (fcount_next == 3'd0)
                begin
                    // prefix length form
                    pfx_shamt = 6'd32 - acc_next[5:0];
                    if (!seen_next)
                    begin
                        if (err_next == ipv4_cidr_pkg::ST_OK)
                            err_next = ipv4_cidr_pkg::ST_MISSING;
                    end
                    else if (acc_next > 10'd32)
                    begin
                        if (err_next == ipv4_cidr_pkg::ST_OK)
                            err_next = ipv4_cidr_pkg::ST_PREFIX;
                    end
                    else if (acc_next == 10'd0)
                        mask_next = '0;
                    else
                        mask_next = 32'hffff_ffff << pfx_shamt;
                end
                else if (fcount_next != 3'd3)
                begin
                    if (err_next == ipv4_cidr_pkg::ST_OK)
                        err_next = ipv4_cidr_pkg::ST_MISSING;
                end
                else
                begin
                    fld = ipv4_cidr_pkg::close_field(seen_next, acc_next, err_next,
                                                     mask_next);
                    err_next  = fld.err;
                    mask_next = fld.shift;
                end
            end
            phase_next = ipv4_cidr_pkg::PH_DONE;
        end

        // result word; address and mask read zero on error
        out_word_next.address         = (err_next == ipv4_cidr_pkg::ST_OK) ? addr_next : '0;
        out_word_next.netmask         = (err_next == ipv4_cidr_pkg::ST_OK) ? mask_next : '0;
        out_word_next.consumed_length = pos_next;
        out_word_next.status          = err_next;
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (!in_stall)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
            s1_word_reg <= in_word;
    end

    // parse state; cleared after the last character of each token
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= ipv4_cidr_pkg::PH_ADDR;
            fcount_reg <= '0;
            acc_reg    <= '0;
            seen_reg   <= 1'b0;
            addr_reg   <= '0;
            mask_reg   <= '0;
            err_reg    <= ipv4_cidr_pkg::ST_OK;
            pos_reg    <= '0;
        end
        else if (proc)
        begin
            if (s1_word_reg.is_last)
            begin
                phase_reg  <= ipv4_cidr_pkg::PH_ADDR;
                fcount_reg <= '0;
                acc_reg    <= '0;
                seen_reg   <= 1'b0;
                addr_reg   <= '0;
                mask_reg   <= '0;
                err_reg    <= ipv4_cidr_pkg::ST_OK;
                pos_reg    <= '0;
            end
            else
            begin
                phase_reg  <= phase_next;
                fcount_reg <= fcount_next;
                acc_reg    <= acc_next;
                seen_reg   <= seen_next;
                addr_reg   <= addr_next;
                mask_reg   <= mask_next;
                err_reg    <= err_next;
                pos_reg    <= pos_next;
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (proc && s1_word_reg.is_last)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (proc && s1_word_reg.is_last)
            out_word_reg <= out_word_next;
    end

endmodule

`default_nettype wire
